/* design/ckf_pkg.sv */
// ---------------------------------------------------------------------------
// Cyclic keyframe interpolator package
// Operation and status codes, register indexes and the keyframe word type.
// ---------------------------------------------------------------------------
package ckf_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;

    typedef struct packed {
        logic        [15:0] tm;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } key_t;

    typedef struct packed {
        logic load;
        logic pick_new;
    } cell_ctrl_t;

endpackage

/* design/cyclic_keyframe_interpolator_top.sv */
// ---------------------------------------------------------------------------
// Cyclic keyframe interpolator
// Time-sorted keyframe table in a row of cells with periodic linear lookup.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the result word is presented. Each word gives exactly one result, shown
// for one cycle with done high on status, out_x and out_y. The receiver
// cannot stall, so the result is simply presented once.
// An add or clear goes from acceptance through an execute state to output.
// An interpolating query passes the serial modulo unit, a selection and a
// multiply state, then the two serial interpolation dividers. A query that
// lands on a keyframe or past the last one skips the multiply and the
// dividers; an empty-cycle query goes straight to output. Items are handled
// one at a time. Offsets are written through write_enable, write_index and
// write_data; the user must write them only while busy is low, which the
// block does not enforce. Reset leaves only the start point (0,0), a zero
// cycle length and zero offsets; no clearing pass is needed.
// ---------------------------------------------------------------------------
module cyclic_keyframe_interpolator_top
    import ckf_pkg::*;
#(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [15:0]        time_point,
    input  logic signed [15:0] key_x,
    input  logic signed [15:0] key_y,
    input  logic               write_enable,
    input  logic [1:0]         write_index,
    input  logic [15:0]        write_data,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [16:0] out_x,
    output logic signed [16:0] out_y
);

    localparam int CW = $clog2(MAX_KEYFRAMES + 1);
    localparam int IW = $clog2(MAX_KEYFRAMES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_SEL  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]         op_reg;
    key_t               item_reg;
    logic [15:0]        cmp_reg, cmp_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [15:0]        cycle_reg, cycle_next;
    logic signed [15:0] sp_x_reg, sp_x_next, sp_y_reg, sp_y_next;
    logic signed [15:0] off_x_reg, off_x_next, off_y_reg, off_y_next;
    logic [1:0]         st_reg, st_next;
    logic signed [16:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic signed [15:0] p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic signed [15:0] p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic [15:0]        num_reg, num_next, den_reg, den_next;
    logic [31:0]        prx_reg, prx_next, pry_reg, pry_next;
    logic               negx_reg, negx_next, negy_reg, negy_next;
    logic               done_reg, done_next;
    logic [1:0]         ost_reg;
    logic signed [16:0] ox_reg, oy_reg;

    key_t       ent [MAX_KEYFRAMES];
    cell_ctrl_t ctrl [MAX_KEYFRAMES];
    logic [MAX_KEYFRAMES-1:0] c_lt, c_eq, lt_v, le_v;

    logic          do_insert, dup, full;
    logic [IW-1:0] k;
    logic [IW:0]   k1;
    key_t          sel0, sel1;

    logic        mod_go, mod_done, lerp_go, dx_done, dy_done;
    logic [15:0] mod_q, mod_r, dx_r, dy_r;
    logic [31:0] dx_q, dy_q;

    logic signed [16:0] rise_x, rise_y, qx, qy;
    logic [15:0]        mag_x, mag_y;

    assign ent[0]  = '{tm: 16'd0, x: sp_x_reg, y: sp_y_reg};
    assign c_lt[0] = 1'b1;
    assign c_eq[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 1; gi < MAX_KEYFRAMES; gi++)
        begin : g_cell
            ckf_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl[gi]),
                .nbr      (ent[gi-1]),
                .item     (item_reg),
                .cmp_time (cmp_reg),
                .key      (ent[gi]),
                .lt       (c_lt[gi]),
                .eq       (c_eq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        lt_v[0] = 1'b1;
        le_v[0] = 1'b0;
        dup     = 1'b0;
        ctrl[0] = '{load: 1'b0, pick_new: 1'b0};
        for (int i = 1; i < MAX_KEYFRAMES; i++)
        begin
            lt_v[i] = c_lt[i] && (CW'(i) < count_reg);
            le_v[i] = (c_lt[i] || c_eq[i]) && (CW'(i) < count_reg);
            dup     = dup || (c_eq[i] && (CW'(i) < count_reg));
        end
        full      = count_reg == CW'(MAX_KEYFRAMES);
        do_insert = state_reg == S_EXEC && op_reg == OP_ADD && item_reg.tm != 16'd0
                    && !dup && !full;
        for (int i = 1; i < MAX_KEYFRAMES; i++)
        begin
            ctrl[i].pick_new = lt_v[i-1];
            ctrl[i].load     = do_insert && (CW'(i) <= count_reg)
                               && (!lt_v[i-1] || !lt_v[i]);
        end
    end

    always_comb
    begin
        k    = IW'($countones(le_v));
        k1   = {1'b0, k} + 1'b1;
        sel0 = ent[0];
        sel1 = ent[0];
        for (int i = 0; i < MAX_KEYFRAMES; i++)
        begin
            if (IW'(i) == k)
            begin
                sel0 = ent[i];
            end
            if ((IW+1)'(i) == k1)
            begin
                sel1 = ent[i];
            end
        end
    end

    assign mod_go  = state_reg == S_EXEC && op_reg == OP_QUERY && cycle_reg != 16'd0;
    assign lerp_go = state_reg == S_MUL;

    ckf_div #(.NUM_W(16), .DEN_W(16)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .numer     (item_reg.tm),
        .denom     (cycle_reg),
        .quotient  (mod_q),
        .remainder (mod_r),
        .done      (mod_done)
    );

    ckf_div #(.NUM_W(32), .DEN_W(16)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (lerp_go),
        .numer     (prx_next),
        .denom     (den_reg),
        .quotient  (dx_q),
        .remainder (dx_r),
        .done      (dx_done)
    );

    ckf_div #(.NUM_W(32), .DEN_W(16)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (lerp_go),
        .numer     (pry_next),
        .denom     (den_reg),
        .quotient  (dy_q),
        .remainder (dy_r),
        .done      (dy_done)
    );

    always_comb
    begin
        rise_x = 17'(p1x_reg) - 17'(p0x_reg);
        rise_y = 17'(p1y_reg) - 17'(p0y_reg);
        mag_x  = rise_x[16] ? 16'(-rise_x) : rise_x[15:0];
        mag_y  = rise_y[16] ? 16'(-rise_y) : rise_y[15:0];
        qx     = negx_reg ? -$signed(dx_q[16:0]) : $signed(dx_q[16:0]);
        qy     = negy_reg ? -$signed(dy_q[16:0]) : $signed(dy_q[16:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        cmp_next   = cmp_reg;
        count_next = count_reg;
        cycle_next = cycle_reg;
        sp_x_next  = sp_x_reg;
        sp_y_next  = sp_y_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        st_next    = st_reg;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        p0x_next   = p0x_reg;
        p0y_next   = p0y_reg;
        p1x_next   = p1x_reg;
        p1y_next   = p1y_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        prx_next   = prx_reg;
        pry_next   = pry_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        done_next  = 1'b0;
        if (write_enable && write_index == REG_OFFSET_X)
        begin
            off_x_next = $signed(write_data);
        end
        if (write_enable && write_index == REG_OFFSET_Y)
        begin
            off_y_next = $signed(write_data);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmp_next   = time_point;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next    = ST_OK;
                res_x_next = '0;
                res_y_next = '0;
                state_next = S_OUT;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (item_reg.tm == 16'd0)
                        begin
                            sp_x_next = item_reg.x;
                            sp_y_next = item_reg.y;
                        end
                        else if (dup)
                        begin
                            st_next = ST_DUP;
                        end
                        else if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            if (item_reg.tm > cycle_reg)
                            begin
                                cycle_next = item_reg.tm;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (cycle_reg == 16'd0)
                        begin
                            st_next    = ST_EMPTY;
                            res_x_next = 17'(sp_x_reg);
                            res_y_next = 17'(sp_y_reg);
                        end
                        else
                        begin
                            state_next = S_MOD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = CW'(1);
                        cycle_next = '0;
                        sp_x_next  = '0;
                        sp_y_next  = '0;
                        off_x_next = '0;
                        off_y_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    cmp_next   = mod_r;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                p0x_next = sel0.x;
                p0y_next = sel0.y;
                p1x_next = sel1.x;
                p1y_next = sel1.y;
                num_next = cmp_reg - sel0.tm;
                den_next = sel1.tm - sel0.tm;
                if (k1 >= (IW+1)'(count_reg) || sel0.tm == cmp_reg)
                begin
                    res_x_next = 17'(sel0.x);
                    res_y_next = 17'(sel0.y);
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prx_next   = mag_x * num_reg;
                pry_next   = mag_y * num_reg;
                negx_next  = rise_x[16];
                negy_next  = rise_y[16];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dx_done)
                begin
                    res_x_next = 17'(p0x_reg) + qx;
                    res_y_next = 17'(p0y_reg) + qy;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            cycle_reg <= '0;
            sp_x_reg  <= '0;
            sp_y_reg  <= '0;
            off_x_reg <= '0;
            off_y_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cycle_reg <= cycle_next;
            sp_x_reg  <= sp_x_next;
            sp_y_reg  <= sp_y_next;
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= operation;
            item_reg <= '{tm: time_point, x: key_x, y: key_y};
        end
        cmp_reg   <= cmp_next;
        st_reg    <= st_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        p0x_reg   <= p0x_next;
        p0y_reg   <= p0y_next;
        p1x_reg   <= p1x_next;
        p1y_reg   <= p1y_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        prx_reg   <= prx_next;
        pry_reg   <= pry_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        if (state_reg == S_OUT)
        begin
            ost_reg <= st_reg;
            ox_reg  <= (op_reg == OP_QUERY) ? res_x_reg + 17'(off_x_reg) : res_x_reg;
            oy_reg  <= (op_reg == OP_QUERY) ? res_y_reg + 17'(off_y_reg) : res_y_reg;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign status = ost_reg;
    assign out_x  = ox_reg;
    assign out_y  = oy_reg;

endmodule

/* design/ckf_cell.sv */
// ---------------------------------------------------------------------------
// Keyframe cell
// Holds one keyframe, loads a new one or its left neighbor's on an insert.
// ---------------------------------------------------------------------------
module ckf_cell
    import ckf_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  key_t        nbr,
    input  key_t        item,
    input  logic [15:0] cmp_time,
    output key_t        key,
    output logic        lt,
    output logic        eq
);

    key_t key_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg <= ctrl.pick_new ? item : nbr;
        end
    end

    assign key = key_reg;
    assign lt  = key_reg.tm < cmp_time;
    assign eq  = key_reg.tm == cmp_time;

endmodule

/* design/ckf_div.sv */
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ckf_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] trial;

    always_comb
    begin
        trial     = {1'b0, r_reg, q_reg[NUM_W-1]} - {2'b00, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (go)
        begin
            q_next   = numer;
            r_next   = '0;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DEN_W+1])
            begin
                r_next = trial[DEN_W-1:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_W-2:0], q_reg[NUM_W-1]};
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = cnt_reg == CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (go)
        begin
            d_reg <= denom;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

endmodule
